>>> rtl/rhsd_pkg.sv
`default_nettype none

package rhsd_pkg;

  localparam int unsigned SPEED_W   = 9;
  localparam int unsigned DUTY_W    = 8;
  localparam int unsigned STEP_IV_W = 24;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [STEP_IV_W-1:0] STEP_IV_RESET = 24'd1000;

  // The only 9-bit pattern outside +-255 and the value it is clamped to.
  localparam logic signed [SPEED_W-1:0] SPEED_LOW_RAW = 9'sh100;
  localparam logic signed [SPEED_W-1:0] SPEED_LOW_SAT = 9'sh101;

  typedef enum logic [0:0] {
    OP_SET_SPEED = 1'b0,
    OP_TICK      = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONE_WIRE_MODE = 1'b0,
    CFG_STEP_INTERVAL = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [DUTY_W-1:0] a_duty;
    logic [DUTY_W-1:0] b_duty;
  } duty_pair_t;

endpackage

`default_nettype wire

>>> rtl/rhsd_duty_map.sv
`default_nettype none

// Maps a signed speed onto the two H-bridge pin duties.
module rhsd_duty_map (
  input  logic                                  one_wire_mode_i,
  input  logic signed [rhsd_pkg::SPEED_W-1:0]   speed_i,
  output rhsd_pkg::duty_pair_t                  duty_o
);
  import rhsd_pkg::*;

  logic [SPEED_W-1:0] mag_wide;
  logic [DUTY_W-1:0]  mag;
  logic               is_pos;
  logic               is_neg;

  assign is_neg   = speed_i[SPEED_W-1];
  assign is_pos   = !is_neg && (speed_i != '0);
  assign mag_wide = is_neg ? (~speed_i + {{(SPEED_W-1){1'b0}}, 1'b1}) : speed_i;
  assign mag      = mag_wide[DUTY_W-1:0];

  always_comb begin
    duty_o = '0;
    if (one_wire_mode_i) begin
      duty_o.a_duty = mag;
      duty_o.b_duty = is_pos ? {DUTY_W{1'b1}} : '0;
    end else if (is_pos) begin
      duty_o.a_duty = mag;
    end else if (is_neg) begin
      duty_o.b_duty = mag;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ramped_hbridge_speed_drive.sv
// Ramped H-bridge speed drive.
// The input channel carries one item per transfer: either a set-speed command
// (opcode 0, with a signed speed and a ramp flag) or a one-microsecond tick
// (opcode 1). Every accepted item produces exactly one result transfer on the
// output channel: the duty for pin A, the duty for pin B and the signed speed
// now being driven.
// The configuration channel writes one_wire_mode (index 0) and step_interval
// (index 1); it is always ready and should only be used while the block is idle.
// The result of an item accepted at a clock edge is valid right after that
// edge. An item can be accepted in every cycle while the receiver takes the
// results, so throughput is one item per cycle; the state update and duty
// mapping sit between the input ports and the single result register.
// When the receiver stalls, the result register holds its value and the input
// side stays ready only as long as the held result is taken in the same cycle.
// Reset clears the speed, goal, ramp flag and step timer, sets two-wire mode
// and a step interval of 1000 ticks, and empties the result register.
`default_nettype none

module ramped_hbridge_speed_drive #(
  parameter int unsigned TIMER_WIDTH = 24
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Item input channel
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    opcode_i,
  input  logic signed [rhsd_pkg::SPEED_W-1:0]     speed_i,
  input  logic                                    use_ramp_i,
  // Result output channel
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [rhsd_pkg::DUTY_W-1:0]             a_duty_o,
  output logic [rhsd_pkg::DUTY_W-1:0]             b_duty_o,
  output logic signed [rhsd_pkg::SPEED_W-1:0]     current_speed_o,
  // Configuration write channel
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [rhsd_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [rhsd_pkg::STEP_IV_W-1:0]          cfg_data_i
);
  import rhsd_pkg::*;

  // Configuration registers.
  logic                   one_wire_mode_q;
  logic [STEP_IV_W-1:0]   step_interval_q;

  // Drive state.
  logic signed [SPEED_W-1:0] present_q, present_d;
  logic signed [SPEED_W-1:0] goal_q, goal_d;
  logic                      ramp_q, ramp_d;
  logic [TIMER_WIDTH-1:0]    wait_q, wait_d;

  // Result register.
  logic                      out_valid_q;
  logic [DUTY_W-1:0]         a_duty_q;
  logic [DUTY_W-1:0]         b_duty_q;
  logic signed [SPEED_W-1:0] current_speed_q;

  logic                      in_fire;
  logic                      cfg_fire;
  logic signed [SPEED_W-1:0] target;
  logic [TIMER_WIDTH-1:0]    iv_sat;
  logic [TIMER_WIDTH-1:0]    wait_eff;
  logic                      do_step;
  duty_pair_t                duty;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  // The step interval is clamped to what the timer can hold.
  generate
    if (TIMER_WIDTH > STEP_IV_W) begin : g_iv_wide
      assign iv_sat = {{(TIMER_WIDTH-STEP_IV_W){1'b0}}, step_interval_q};
    end else if (TIMER_WIDTH == STEP_IV_W) begin : g_iv_same
      assign iv_sat = step_interval_q;
    end else begin : g_iv_narrow
      assign iv_sat = (|step_interval_q[STEP_IV_W-1:TIMER_WIDTH]) ? {TIMER_WIDTH{1'b1}}
                                                                  : step_interval_q[TIMER_WIDTH-1:0];
    end
  endgenerate

  // A raw speed of -256 is clamped to -255.
  assign target = (speed_i == SPEED_LOW_RAW) ? SPEED_LOW_SAT : speed_i;

  always_comb begin
    present_d = present_q;
    goal_d    = goal_q;
    ramp_d    = ramp_q;
    wait_eff  = wait_q;
    if (opcode_i == OP_SET_SPEED) begin
      ramp_d = use_ramp_i;
      goal_d = target;
      if (!use_ramp_i) begin
        present_d = target;
      end
    end else if (wait_q != '0) begin
      wait_eff = wait_q - {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
    end

    // A ramp step is tried after every ramped command and every tick; it is
    // never taken after a jump because ramp_d is then low.
    do_step = ramp_d && (wait_eff == '0) && (present_q != goal_d);
    wait_d  = wait_eff;
    if (do_step) begin
      if (present_q < goal_d) begin
        present_d = present_q + 9'sd1;
      end else begin
        present_d = present_q - 9'sd1;
      end
      wait_d = iv_sat;
    end
  end

  rhsd_duty_map u_duty_map (
    .one_wire_mode_i (one_wire_mode_q),
    .speed_i         (present_d),
    .duty_o          (duty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_wire_mode_q <= 1'b0;
      step_interval_q <= STEP_IV_RESET;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        CFG_ONE_WIRE_MODE: one_wire_mode_q <= cfg_data_i[0];
        CFG_STEP_INTERVAL: step_interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      goal_q      <= '0;
      ramp_q      <= 1'b0;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        present_q <= present_d;
        goal_q    <= goal_d;
        ramp_q    <= ramp_d;
        wait_q    <= wait_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_duty_q        <= duty.a_duty;
      b_duty_q        <= duty.b_duty;
      current_speed_q <= present_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign a_duty_o        = a_duty_q;
  assign b_duty_o        = b_duty_q;
  assign current_speed_o = current_speed_q;

  // The held result always reports the speed that the state registers hold.
  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (current_speed_q == present_q))
    else $error("result speed differs from present speed");

  // The clamp keeps the present speed off the one out-of-range pattern.
  a_speed_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    present_q != SPEED_LOW_RAW)
    else $error("present speed left the range +-255");

  // A tick moves the speed by at most one unit.
  a_tick_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && opcode_i == OP_TICK) |=>
      (present_q == $past(present_q) || present_q == $past(present_q) + 9'sd1 ||
       present_q == $past(present_q) - 9'sd1))
    else $error("tick moved speed by more than one unit");

  // While the timer is well above zero a tick only counts it down.
  a_timer_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && opcode_i == OP_TICK && wait_q > {{(TIMER_WIDTH-1){1'b0}}, 1'b1}) |=>
      (wait_q == $past(wait_q) - {{(TIMER_WIDTH-1){1'b0}}, 1'b1} &&
       present_q == $past(present_q)))
    else $error("step timer did not count down");

  // A new item is only taken when the result register is free or draining.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_fire)
    else $error("held result overwritten");

endmodule

`default_nettype wire
